@@ rtl/core/blm_pkg.sv @@
// blm_pkg: types and constants shared by the barycentric interpolation core
// used by blm_div and barycentric_lagrange_interp; no dependencies
package blm_pkg;

  localparam int unsigned NumW = 102;
  localparam int unsigned DenW = 70;
  localparam int unsigned TW   = 62;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         node_index;
    logic signed [31:0] node_coord_in;
    logic signed [47:0] weight_in;
    logic signed [31:0] value_in;
    logic signed [31:0] query_point;
  } in_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               on_node;
    logic               divide_fault;
  } out_t;

  typedef struct packed {
    logic signed [31:0] coord;
    logic signed [47:0] weight;
    logic signed [31:0] value;
  } ent_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

@@ rtl/core/blm_ram.sv @@
// blm_ram: generic simple dual port ram with registered read
// no dependencies
module blm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/blm_div.sv @@
// blm_div: unsigned restoring divider, one quotient bit per cycle
// depends on blm_pkg for operand widths
module blm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [blm_pkg::NumW-1:0]   num_i,
  input  logic [blm_pkg::DenW-1:0]   den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [blm_pkg::NumW-1:0]   quot_o
);

  localparam int unsigned CntW = $clog2(blm_pkg::NumW + 1);

  logic [blm_pkg::NumW-1:0] sh_q, sh_d;
  logic [blm_pkg::DenW-1:0] rem_q, rem_d, den_q;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [blm_pkg::DenW:0]   trial;
  logic [blm_pkg::DenW:0]   diff;

  assign trial = {rem_q, sh_q[blm_pkg::NumW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(blm_pkg::NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[blm_pkg::DenW]) begin
        rem_d = diff[blm_pkg::DenW-1:0];
        sh_d  = {sh_q[blm_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[blm_pkg::DenW-1:0];
        sh_d  = {sh_q[blm_pkg::NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

@@ rtl/core/barycentric_lagrange_interp.sv @@
// barycentric_lagrange_interp: fixed point barycentric lagrange interpolation
// depends on blm_pkg, blm_ram and blm_div
//
// input channel: in_valid_i / in_stall_o / in_data_i, one beat per item.
//   a load beat writes coordinate, weight and value of one node entry
//   (indices at or beyond NODES are dropped); a query beat gives a point.
// output channel: out_valid_o / out_stall_i / out_data_o, one beat per query.
// config: cfg_we_i writes poly_order from cfg_wdata_i. the user must write it
// only while the core is idle; the block itself does not enforce this.
// a query runs node by node from entry zero: ram read, distance check,
//   division per node, then two multiply steps and an accumulate; a final
//   division ends the query. the serial divider sets the pace, and a query
//   ends early when the point hits a node. one item is in work at a time.
// the result sits in an output register; the next item is taken while it
// waits, and a finished query waits for that register when the receiver stalls.
// reset clears control state and sets poly_order to one; the node tables
// hold no reset value and must be loaded before use.
module barycentric_lagrange_interp #(
  parameter int unsigned NODES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  blm_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output blm_pkg::out_t       out_data_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i
);

  localparam int unsigned IW   = $clog2(NODES);
  localparam int unsigned EntW = $bits(blm_pkg::ent_t);

  typedef enum logic [9:0] {
    IDLE  = 10'b0000000001,
    RD    = 10'b0000000010,
    CHK   = 10'b0000000100,
    DIV   = 10'b0000001000,
    MUL0  = 10'b0000010000,
    MUL1  = 10'b0000100000,
    ACC   = 10'b0001000000,
    FIN   = 10'b0010000000,
    FWAIT = 10'b0100000000,
    DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]                  order_q;
  logic [IW-1:0]               idx_q, idx_d, last;
  logic signed [31:0]          x_q;
  logic                        wneg_q, dneg_q, fneg_q, tneg_q;
  logic [31:0]                 fmag_q;
  logic [blm_pkg::TW-1:0]      tm_q;
  logic [62:0]                 p0_q, p1_q;
  logic signed [blm_pkg::NumW-1:0] num_q;
  logic signed [blm_pkg::DenW-1:0] den_q;
  blm_pkg::out_t               res_q, out_q;
  logic                        out_valid_q;

  blm_pkg::ent_t               wr_ent, rd_ent;
  logic [EntW-1:0]             rdata;
  logic                        in_acc, ld_we;

  logic signed [32:0]          d_diff;
  logic [32:0]                 dmag;
  logic [47:0]                 wmag;
  logic [31:0]                 fmag;

  logic                        div_start, div_busy, div_done;
  logic [blm_pkg::NumW-1:0]    div_num, div_quot;
  logic [blm_pkg::DenW-1:0]    div_den;
  logic [blm_pkg::TW-1:0]      tm_sat;
  logic [93:0]                 term;
  logic [blm_pkg::NumW-1:0]    num_mag;
  logic [blm_pkg::DenW-1:0]    den_mag;
  logic                        res_neg;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != IDLE);
  assign ld_we      = in_acc && (in_data_i.req_type == blm_pkg::REQ_LOAD)
                      && (32'(in_data_i.node_index) < NODES);

  assign last = (32'(order_q) < NODES - 1) ? IW'(order_q) : IW'(NODES - 1);

  assign wr_ent.coord  = in_data_i.node_coord_in;
  assign wr_ent.weight = in_data_i.weight_in;
  assign wr_ent.value  = in_data_i.value_in;

  blm_ram #(.Width(EntW), .Depth(NODES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (IW'(in_data_i.node_index)),
    .wdata_i (wr_ent),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign rd_ent = rdata;
  assign d_diff = 33'(x_q) - 33'(rd_ent.coord);
  assign dmag   = d_diff[32] ? 33'(-d_diff) : 33'(d_diff);
  assign wmag   = rd_ent.weight[47] ? 48'(-rd_ent.weight) : 48'(rd_ent.weight);
  assign fmag   = rd_ent.value[31] ? 32'(-rd_ent.value) : 32'(rd_ent.value);

  assign num_mag = num_q[blm_pkg::NumW-1] ? blm_pkg::NumW'(-num_q)
                                          : blm_pkg::NumW'(num_q);
  assign den_mag = den_q[blm_pkg::DenW-1] ? blm_pkg::DenW'(-den_q)
                                          : blm_pkg::DenW'(den_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = blm_pkg::NumW'({wmag, 32'b0});
    div_den   = blm_pkg::DenW'(dmag);
    if (state_q == CHK) begin
      div_start = (d_diff != '0);
    end else if (state_q == FIN) begin
      div_start = (den_q != '0);
      div_num   = num_mag;
      div_den   = den_mag;
    end
  end

  blm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign tm_sat = (div_quot[blm_pkg::NumW-1:blm_pkg::TW] != '0) ? '1
                                                                : div_quot[blm_pkg::TW-1:0];
  assign term    = 94'({p1_q, 31'b0}) + 94'(p0_q);
  assign res_neg = num_q[blm_pkg::NumW-1] != den_q[blm_pkg::DenW-1];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      IDLE: begin
        if (in_acc && in_data_i.req_type == blm_pkg::REQ_QUERY) begin
          idx_d   = '0;
          state_d = RD;
        end
      end
      RD:    state_d = CHK;
      CHK:   state_d = (d_diff == '0) ? DONE : DIV;
      DIV:   state_d = div_done ? MUL0 : DIV;
      MUL0:  state_d = MUL1;
      MUL1:  state_d = ACC;
      ACC: begin
        if (idx_q == last) begin
          state_d = FIN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = RD;
        end
      end
      FIN:   state_d = (den_q == '0) ? DONE : FWAIT;
      FWAIT: state_d = div_done ? DONE : FWAIT;
      DONE:  state_d = (!out_valid_q || !out_stall_i) ? IDLE : DONE;
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      idx_q       <= '0;
      order_q     <= 4'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (state_q == DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == IDLE) begin
      x_q   <= in_data_i.query_point;
      num_q <= '0;
      den_q <= '0;
    end
    if (state_q == CHK) begin
      wneg_q <= rd_ent.weight[47];
      dneg_q <= d_diff[32];
      fneg_q <= rd_ent.value[31];
      fmag_q <= fmag;
      if (d_diff == '0) begin
        res_q.interp_value <= rd_ent.value;
        res_q.on_node      <= 1'b1;
        res_q.divide_fault <= 1'b0;
      end
    end
    if (state_q == DIV && div_done) begin
      tm_q   <= tm_sat;
      tneg_q <= (wneg_q != dneg_q) && (tm_sat != '0);
    end
    if (state_q == MUL0) begin
      p0_q <= 63'(tm_q[30:0] * fmag_q);
    end
    if (state_q == MUL1) begin
      p1_q <= 63'(tm_q[61:31] * fmag_q);
    end
    if (state_q == ACC) begin
      den_q <= tneg_q ? den_q - blm_pkg::DenW'(tm_q) : den_q + blm_pkg::DenW'(tm_q);
      num_q <= (tneg_q != fneg_q) ? num_q - blm_pkg::NumW'(term)
                                  : num_q + blm_pkg::NumW'(term);
    end
    if (state_q == FIN && den_q == '0) begin
      res_q.on_node      <= 1'b0;
      res_q.divide_fault <= 1'b1;
      if (num_q == '0) begin
        res_q.interp_value <= '0;
      end else if (num_q[blm_pkg::NumW-1]) begin
        res_q.interp_value <= 32'sh80000000;
      end else begin
        res_q.interp_value <= 32'sh7fffffff;
      end
    end
    if (state_q == FWAIT && div_done) begin
      res_q.on_node      <= 1'b0;
      res_q.divide_fault <= 1'b0;
      if (res_neg) begin
        if (div_quot[blm_pkg::NumW-1:32] != '0 || div_quot[31:0] > 32'h80000000) begin
          res_q.interp_value <= 32'sh80000000;
        end else begin
          res_q.interp_value <= 32'(-div_quot[31:0]);
        end
      end else begin
        if (div_quot[blm_pkg::NumW-1:31] != '0) begin
          res_q.interp_value <= 32'sh7fffffff;
        end else begin
          res_q.interp_value <= 32'(div_quot[30:0]);
        end
      end
    end
    if (state_q == DONE && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.on_node && out_data_o.divide_fault))
    else $error("hit and fault flagged together");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == DIV || state_q == FWAIT))
    else $error("divider running outside a divide state");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != IDLE && state_q != DONE) |-> (idx_q <= last))
    else $error("node index past the order");

endmodule

@@ test/blm_checker.sv @@
// blm_checker: watches the ports of barycentric_lagrange_interp, predicts every
// query result from its own node tables and compares; depends on blm_pkg
`timescale 1ns / 100ps

module blm_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  blm_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  blm_pkg::out_t out_data_i,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_wdata_i,
  output int            errors_o,
  output int            pending_o
);

  localparam logic [127:0] TMax = (128'd1 << blm_pkg::TW) - 128'd1;

  logic signed [31:0] coord_q [16];
  logic signed [47:0] weight_q [16];
  logic signed [31:0] value_q [16];
  logic [3:0]         order_q;
  blm_pkg::out_t      interp_q [$];
  int                 err_cnt;

  function automatic blm_pkg::out_t interpolate(logic signed [31:0] x);
    logic [127:0]  num, den, wm, dm, fm, q, tm, term, nm, dnm;
    longint        d, w, f;
    logic          tneg;
    blm_pkg::out_t r;
    int            j;
    num = '0;
    den = '0;
    for (j = 0; j <= order_q; j++) begin
      d = longint'(x) - longint'(coord_q[j]);
      w = longint'(weight_q[j]);
      f = longint'(value_q[j]);
      if (d == 0) begin
        r.interp_value = value_q[j];
        r.on_node = 1'b1;
        r.divide_fault = 1'b0;
        return r;
      end
      wm = 128'(w < 0 ? -w : w);
      dm = 128'(d < 0 ? -d : d);
      fm = 128'(f < 0 ? -f : f);
      q = (wm << 32) / dm;
      tm = (q > TMax) ? TMax : q;
      tneg = ((w < 0) != (d < 0)) && (tm != 0);
      den = tneg ? den - tm : den + tm;
      term = tm * fm;
      num = (tneg != (f < 0)) ? num - term : num + term;
    end
    r.on_node = 1'b0;
    if (den == 0) begin
      r.divide_fault = 1'b1;
      r.interp_value = (num == 0) ? 32'sh0 : (num[127] ? 32'sh8000_0000 : 32'sh7fff_ffff);
      return r;
    end
    r.divide_fault = 1'b0;
    nm = num[127] ? -num : num;
    dnm = den[127] ? -den : den;
    q = nm / dnm;
    if (num[127] != den[127]) begin
      r.interp_value = (q > 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
    end else begin
      r.interp_value = (q > 128'h7fff_ffff) ? 32'sh7fff_ffff : q[31:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blm_pkg::out_t exp_r;
    if (!rst_ni) begin
      order_q = 4'd1;
      interp_q.delete();
      err_cnt = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) order_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.req_type == blm_pkg::REQ_LOAD) begin
          coord_q[in_data_i.node_index] = in_data_i.node_coord_in;
          weight_q[in_data_i.node_index] = in_data_i.weight_in;
          value_q[in_data_i.node_index] = in_data_i.value_in;
        end else begin
          interp_q.push_back(interpolate(in_data_i.query_point));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (interp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat value=%h on_node=%b fault=%b", $time,
                   out_data_i.interp_value, out_data_i.on_node, out_data_i.divide_fault);
        end else begin
          exp_r = interp_q.pop_front();
          if (out_data_i.interp_value !== exp_r.interp_value
              || out_data_i.on_node !== exp_r.on_node
              || out_data_i.divide_fault !== exp_r.divide_fault) begin
            err_cnt++;
            $display("%0t: mismatch expected value=%h on_node=%b fault=%b", $time,
                     exp_r.interp_value, exp_r.on_node, exp_r.divide_fault);
            $display("%0t:          actual   value=%h on_node=%b fault=%b", $time,
                     out_data_i.interp_value, out_data_i.on_node, out_data_i.divide_fault);
          end
        end
      end
      errors_o <= err_cnt;
      pending_o <= interp_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
// tb: stimulus and verdict for barycentric_lagrange_interp
// depends on blm_pkg, the block and blm_checker
`timescale 1ns / 100ps

module tb;

  localparam int InW = $bits(blm_pkg::in_t);

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  blm_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  blm_pkg::out_t out_data_o;
  logic          cfg_we_i = 1'b0;
  logic [3:0]    cfg_wdata_i = 4'd0;
  int            errors;
  int            pending;
  int            in_idle = 0;
  int            out_idle = 0;
  logic [3:0]    order = 4'd1;
  logic signed [31:0] coord_m [16];

  always #5 clk_i = ~clk_i;

  barycentric_lagrange_interp u_top (.*);

  blm_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_wdata_i, .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < out_idle);

  task automatic send(blm_pkg::in_t it);
    while ($urandom_range(99) < in_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    if (it.req_type == blm_pkg::REQ_LOAD) coord_m[it.node_index] = it.node_coord_in;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_order(logic [3:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    order = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load(logic [3:0] idx, logic [31:0] c, logic [47:0] w, logic [31:0] v);
    blm_pkg::in_t it;
    it = InW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.req_type = blm_pkg::REQ_LOAD;
    it.node_index = idx;
    it.node_coord_in = c;
    it.weight_in = w;
    it.value_in = v;
    send(it);
  endtask

  task automatic query(logic [31:0] x);
    blm_pkg::in_t it;
    it = InW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.req_type = blm_pkg::REQ_QUERY;
    it.query_point = x;
    send(it);
  endtask

  function automatic logic [31:0] rand_point();
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h4000_0000 : 32'hc000_0000;
      default: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  task automatic rand_item();
    logic [47:0] w;
    logic [31:0] v;
    if ($urandom_range(99) < 40) begin
      w = 48'({$urandom, $urandom});
      if ($urandom_range(3) == 0) w = $signed(w) >>> $urandom_range(47);
      if ($urandom_range(15) == 0) w = '0;
      v = $urandom;
      if ($urandom_range(1)) v = $signed(v) >>> $urandom_range(31);
      load(4'($urandom), ($urandom_range(7) == 0) ? coord_m[$urandom_range(15)] : rand_point(),
           w, v);
    end else begin
      query(($urandom_range(9) < 3) ? coord_m[$urandom_range(order)] : rand_point());
    end
  endtask

  initial begin
    logic [3:0] orders [8] = '{4'd0, 4'd2, 4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd4};
    int         counts [8] = '{120, 120, 40, 120, 120, 120, 120, 120};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int j = 0; j < 16; j++) begin
      load(4'(j), (j == 15) ? 32'h4000_0000 : 32'hc000_0000 + (j << 27),
           (j == 4) ? 48'h7fff_ffff_ffff : (j == 5) ? 48'h8000_0000_0000
           : (j % 2 ? -((j + 1) << 24) : ((j + 1) << 24)),
           (j == 2) ? 32'h7fff_ffff : (j == 3) ? 32'h8000_0000 : (j << 16));
    end
    query(coord_m[0]);
    query(coord_m[1]);
    query(32'h0);
    query(32'h8000_0000);
    query(32'h7fff_ffff);
    // cancelling weights around zero
    load(0, 32'hf000_0000, 48'h0100_0000, 32'h0005_0000);
    load(1, 32'h1000_0000, 48'h0100_0000, 32'h0007_0000);
    query(32'h0);
    load(1, 32'h1000_0000, 48'h0100_0000, 32'h0003_0000);
    query(32'h0);
    load(0, 32'hf000_0000, 48'h0, 32'h0005_0000);
    load(1, 32'h1000_0000, 48'h0, 32'h0003_0000);
    query(32'h0);
    // saturated term with a tiny distance
    load(0, 32'h1, 48'h7fff_ffff_ffff, 32'h7fff_ffff);
    load(1, 32'h1000_0000, 48'h8000_0000_0000, 32'h8000_0000);
    query(32'h0);
    set_order(4'd15);
    query(32'h4000_0000);
    query(32'h0123_4567);
    in_idle = 17;
    out_idle = 73;
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        in_idle = 73;
        out_idle = 17;
      end else if (p == 6) begin
        in_idle = 0;
        out_idle = 0;
      end
      set_order(orders[p]);
      for (int k = 0; k < counts[p]; k++) begin
        if (k == counts[p] / 2) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        rand_item();
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
